@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL in this folder.
// Needs nothing else; ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check outside reset only
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// check on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RUN(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hdl/pngcd_pkg.sv @@
// Types and constants for the PNG chunk deframer.
// No dependencies.
package pngcd_pkg;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_CRC
  } phase_t;

  localparam int unsigned CNT_W = 3;

  localparam logic [CNT_W-1:0] SIG_LAST   = 3'd7;  // eighth signature byte
  localparam logic [CNT_W-1:0] FIELD_LAST = 3'd3;  // fourth byte of a field

  localparam logic [31:0] SIG_BYTES      = 32'd8;
  localparam logic [32:0] CHUNK_OVERHEAD = 33'd12;
  localparam logic [32:0] LEN_FIELD      = 33'd4;
  localparam logic [31:0] DATA_SKIP      = 32'd8;  // length and type fields
  localparam logic [31:0] TYPE_IEND      = 32'h49454E44;

endpackage

@@ hdl/png_chunk_deframer_unit.sv @@
// PNG chunk deframer: walks a PNG byte stream and emits one record per chunk.
// Depends on pngcd_pkg and assert_macros.svh.
//
// Takes one file byte per cycle with no gaps required, one transfer every clock at
// full rate unless a record waits on a stalled output. A byte goes into an input
// register and is parsed there; a chunk record lands in the output register, taken
// from the chunk's last CRC byte in the input register. The input register holds
// one more byte while a record waits. The 8-byte signature is skipped unchecked;
// parsing stops after IEND or when file_size cannot hold the next length field or
// chunk; it resumes only after reset or on a start-of-file byte. CRC is not checked.
`include "assert_macros.svh"

module png_chunk_deframer_unit (
  input  logic         clk,
  input  logic         rst,
  // configuration: file size in bytes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  // byte input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  logic         s_axis_tuser,   // [0] start_of_file
  // chunk records
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [31:0] chunk_length, [63:32] data_offset,
                                       // [95:64] chunk_type, [127:96] chunk_crc
  output logic         m_axis_tuser    // [0] is_end_chunk
);

  logic [31:0] file_size;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_sof;
  logic        adv;

  pngcd_pkg::phase_t             phase, phase_next, ph_e;
  logic [pngcd_pkg::CNT_W-1:0]   cnt, cnt_next, cnt_e;
  logic [31:0]                   len, len_next, len_e, len_full;
  logic [31:0]                   typ, typ_next, typ_e, typ_full;
  logic [31:0]                   crc, crc_next, crc_e, crc_full;
  logic [31:0]                   data_left, data_left_next;
  logic [31:0]                   origin, origin_next;
  logic [32:0]                   origin12, origin12_next;
  logic [31:0]                   chunk_end, chunk_end_next;
  logic                          stopped, stopped_next, stopped_e;

  logic [32:0] origin4;
  logic [33:0] end_sum;
  logic        emit;
  logic        is_end;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (cfg_valid) begin
      file_size <= cfg_data;
    end
  end

  assign adv           = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_sof  <= s_axis_tuser;
    end
  end

  // start of file clears the parse state for this byte
  assign ph_e      = in_sof ? pngcd_pkg::PH_SIG : phase;
  assign cnt_e     = in_sof ? '0 : cnt;
  assign len_e     = in_sof ? '0 : len;
  assign typ_e     = in_sof ? '0 : typ;
  assign crc_e     = in_sof ? '0 : crc;
  assign stopped_e = in_sof ? 1'b0 : stopped;

  assign len_full = {len_e[23:0], in_byte};
  assign typ_full = {typ_e[23:0], in_byte};
  assign crc_full = {crc_e[23:0], in_byte};
  assign origin4  = {1'b0, origin} + pngcd_pkg::LEN_FIELD;
  assign end_sum  = {1'b0, origin12} + {2'b00, len_full};

  always_comb begin
    phase_next     = ph_e;
    cnt_next       = cnt_e;
    len_next       = len_e;
    typ_next       = typ_e;
    crc_next       = crc_e;
    stopped_next   = stopped_e;
    data_left_next = data_left;
    origin_next    = origin;
    origin12_next  = origin12;
    chunk_end_next = chunk_end;
    if (!stopped_e) begin
      case (ph_e)
        pngcd_pkg::PH_SIG: begin
          if (cnt_e == pngcd_pkg::SIG_LAST) begin
            cnt_next      = '0;
            origin_next   = pngcd_pkg::SIG_BYTES;
            origin12_next = {1'b0, pngcd_pkg::SIG_BYTES} + pngcd_pkg::CHUNK_OVERHEAD;
            phase_next    = pngcd_pkg::PH_LEN;
          end else begin
            cnt_next = cnt_e + 1'b1;
          end
        end
        pngcd_pkg::PH_LEN: begin
          if (cnt_e == '0 && origin4 > {1'b0, file_size}) begin
            stopped_next = 1'b1;
          end else begin
            len_next = len_full;
            if (cnt_e == pngcd_pkg::FIELD_LAST) begin
              if (end_sum > {2'b00, file_size}) begin
                stopped_next = 1'b1;
              end else begin
                cnt_next       = '0;
                chunk_end_next = end_sum[31:0];
                phase_next     = pngcd_pkg::PH_TYPE;
              end
            end else begin
              cnt_next = cnt_e + 1'b1;
            end
          end
        end
        pngcd_pkg::PH_TYPE: begin
          typ_next = typ_full;
          if (cnt_e == pngcd_pkg::FIELD_LAST) begin
            cnt_next = '0;
            if (len_e != '0) begin
              data_left_next = len_e;
              phase_next     = pngcd_pkg::PH_DATA;
            end else begin
              phase_next = pngcd_pkg::PH_CRC;
            end
          end else begin
            cnt_next = cnt_e + 1'b1;
          end
        end
        pngcd_pkg::PH_DATA: begin
          if (data_left == 32'd1) begin
            phase_next = pngcd_pkg::PH_CRC;
          end else begin
            data_left_next = data_left - 32'd1;
          end
        end
        default: begin
          crc_next = crc_full;
          if (cnt_e == pngcd_pkg::FIELD_LAST) begin
            if (typ_e == pngcd_pkg::TYPE_IEND) begin
              stopped_next = 1'b1;
            end else begin
              origin_next   = chunk_end;
              origin12_next = {1'b0, chunk_end} + pngcd_pkg::CHUNK_OVERHEAD;
              phase_next    = pngcd_pkg::PH_LEN;
            end
            cnt_next = '0;
            len_next = '0;
            typ_next = '0;
            crc_next = '0;
          end else begin
            cnt_next = cnt_e + 1'b1;
          end
        end
      endcase
    end
  end

  // record on the last CRC byte
  always_comb begin
    emit = 1'b0;
    case (ph_e)
      pngcd_pkg::PH_SIG,
      pngcd_pkg::PH_LEN,
      pngcd_pkg::PH_TYPE,
      pngcd_pkg::PH_DATA: emit = 1'b0;
      default:            emit = !stopped_e && (cnt_e == pngcd_pkg::FIELD_LAST);
    endcase
    is_end = (typ_e == pngcd_pkg::TYPE_IEND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= pngcd_pkg::PH_SIG;
      cnt     <= '0;
      len     <= '0;
      typ     <= '0;
      crc     <= '0;
      stopped <= 1'b0;
    end else if (adv) begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      len     <= len_next;
      typ     <= typ_next;
      crc     <= crc_next;
      stopped <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_left <= data_left_next;
      origin    <= origin_next;
      origin12  <= origin12_next;
      chunk_end <= chunk_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      m_axis_tdata <= {crc_full, typ_e, origin + pngcd_pkg::DATA_SKIP, len_e};
      m_axis_tuser <= is_end;
    end
  end

  `ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !m_axis_tvalid)
  `ASSERT_RUN(a_rec_from_crc, clk, rst,
    $rose(m_axis_tvalid) |-> $past(ph_e == pngcd_pkg::PH_CRC))
  `ASSERT_RUN(a_data_left_live, clk, rst,
    (phase == pngcd_pkg::PH_DATA) |-> (data_left != '0))
  `ASSERT_RUN(a_origin_pair, clk, rst,
    (phase != pngcd_pkg::PH_SIG) |-> (origin12 == (33'(origin) + pngcd_pkg::CHUNK_OVERHEAD)))
  `ASSERT_RUN(a_end_stops, clk, rst,
    (m_axis_tvalid && m_axis_tuser) |-> stopped)

endmodule

@@ test/pngcd_record_checker.sv @@
// Chunk record checker for png_chunk_deframer_unit: follows the byte stream,
// predicts each chunk record and compares it with the record stream.
// Depends on pngcd_pkg for the parse phases.
module pngcd_record_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           mismatches,
  output int           records_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HDR_BYTES   = 32'd8;
  localparam logic [31:0] FIELD_SKIP  = 32'd8;
  localparam logic [33:0] LEN_BYTES   = 34'd4;
  localparam logic [33:0] FRAME_BYTES = 34'd12;
  localparam logic [31:0] IEND_TAG    = 32'h49454E44;

  typedef struct packed {
    logic [31:0] length;
    logic [31:0] offset;
    logic [31:0] kind;
    logic [31:0] crc;
    logic        last;
  } chunk_rec_t;

  pngcd_pkg::phase_t ph;
  logic [31:0] cnt, len_sh, type_sh, crc_sh, origin, fsize;
  logic        halted;
  chunk_rec_t  due_q[$];
  int          err_cnt = 0;

  function void restart_walk();
    ph      = pngcd_pkg::PH_SIG;
    cnt     = '0;
    len_sh  = '0;
    type_sh = '0;
    crc_sh  = '0;
    origin  = '0;
    halted  = 1'b0;
  endfunction

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: chunk record %s: got %h, expected %h", $time, what, got, want);
    err_cnt++;
  endtask

  task walk_byte(input logic [7:0] b, input logic sof);
    chunk_rec_t rec;
    if (sof)
      restart_walk();
    if (halted)
      return;
    case (ph)
      pngcd_pkg::PH_SIG: begin
        cnt++;
        if (cnt >= HDR_BYTES) begin
          cnt    = '0;
          origin = HDR_BYTES;
          ph     = pngcd_pkg::PH_LEN;
        end
      end
      pngcd_pkg::PH_LEN: begin
        if (cnt == 0 && {2'b00, origin} + LEN_BYTES > {2'b00, fsize}) begin
          halted = 1'b1;
          return;
        end
        len_sh = {len_sh[23:0], b};
        cnt++;
        if (cnt >= 4) begin
          if ({2'b00, origin} + {2'b00, len_sh} + FRAME_BYTES > {2'b00, fsize}) begin
            halted = 1'b1;
            return;
          end
          cnt = '0;
          ph  = pngcd_pkg::PH_TYPE;
        end
      end
      pngcd_pkg::PH_TYPE: begin
        type_sh = {type_sh[23:0], b};
        cnt++;
        if (cnt >= 4) begin
          cnt = '0;
          ph  = (len_sh != 0) ? pngcd_pkg::PH_DATA : pngcd_pkg::PH_CRC;
        end
      end
      pngcd_pkg::PH_DATA: begin
        cnt++;
        if (cnt >= len_sh) begin
          cnt = '0;
          ph  = pngcd_pkg::PH_CRC;
        end
      end
      default: begin
        crc_sh = {crc_sh[23:0], b};
        cnt++;
        if (cnt >= 4) begin
          rec.length = len_sh;
          rec.offset = origin + FIELD_SKIP;
          rec.kind   = type_sh;
          rec.crc    = crc_sh;
          rec.last   = (type_sh == IEND_TAG);
          due_q.insert(due_q.size(), rec);
          if (rec.last)
            halted = 1'b1;
          else begin
            origin = origin + len_sh + FRAME_BYTES[31:0];
            ph     = pngcd_pkg::PH_LEN;
          end
          cnt     = '0;
          len_sh  = '0;
          type_sh = '0;
          crc_sh  = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    chunk_rec_t got, want;
    if (rst) begin
      fsize = '0;
      restart_walk();
      due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        fsize = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got.length = m_axis_tdata[31:0];
        got.offset = m_axis_tdata[63:32];
        got.kind   = m_axis_tdata[95:64];
        got.crc    = m_axis_tdata[127:96];
        got.last   = m_axis_tuser;
        if (due_q.size() == 0) begin
          report("with none due, length", got.length, '0);
        end else begin
          want = due_q.pop_front();
          if (got.length !== want.length) report("length", got.length, want.length);
          if (got.offset !== want.offset) report("data offset", got.offset, want.offset);
          if (got.kind !== want.kind) report("type", got.kind, want.kind);
          if (got.crc !== want.crc) report("crc", got.crc, want.crc);
          if (got.last !== want.last) report("end flag", 32'(got.last), 32'(want.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        walk_byte(s_axis_tdata, s_axis_tuser);
    end
    mismatches  <= err_cnt;
    records_due <= due_q.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top for png_chunk_deframer_unit: builds random PNG-like files,
// sets the file size before most files and gives the verdict.
// Depends on the block and pngcd_record_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ITEM_TARGET = 1500;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [31:0] IEND_TAG    = 32'h49454E44;
  localparam logic [31:0] SIZE_MAX    = 32'hFFFFFFFF;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tuser;
  int           mismatches;
  int           records_due;

  int           cycles = 0;
  int           ready_hold = 0;
  int           items_sent = 0;
  bit           no_gaps = 1'b0;
  logic [8:0]   file_q[$];  // {start_of_file, byte}

  png_chunk_deframer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  pngcd_record_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .mismatches    (mismatches),
    .records_due   (records_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // record sink: runs of ready and stalls, short and long
  always @(posedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_tready <= 1'b1;
        ready_hold = $urandom_range(0, 15);
      end else if (r < 85) begin
        m_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else if (r < 95) begin
        m_tready <= 1'b1;
        ready_hold = $urandom_range(40, 120);
      end else begin
        m_tready <= 1'b0;
        ready_hold = $urandom_range(10, 50);
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task send_byte(input logic [7:0] b, input logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task send_file();
    foreach (file_q[i])
      send_byte(file_q[i][7:0], file_q[i][8]);
  endtask

  // size changes only with no byte in flight and no record outstanding
  task write_size(input logic [31:0] v);
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (records_due != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function void push_byte(input logic [7:0] b);
    file_q.insert(file_q.size(), {1'b0, b});
  endfunction

  function void push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--)
      push_byte(w[8*i +: 8]);
  endfunction

  function logic [31:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 3);
    if (r < 85) return $urandom_range(4, 16);
    return $urandom_range(17, 48);
  endfunction

  function logic [31:0] pick_kind();
    int r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      for (int i = 0; i < 4; i++)
        k[8*i +: 8] = 8'($urandom_range(65, 90)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
    end else if (r < 90) begin
      k = $urandom;
    end else begin
      k = IEND_TAG ^ (32'h1 << $urandom_range(0, 31));
    end
    return k;
  endfunction

  function void build_file();
    int n;
    logic [31:0] len;
    file_q.delete();
    if ($urandom_range(0, 1)) begin
      push_word(32'h89504E47);
      push_word(32'h0D0A1A0A);
    end else begin
      push_word($urandom);
      push_word($urandom);
    end
    n = $urandom_range(0, 4);
    for (int c = 0; c < n; c++) begin
      len = pick_len();
      if ($urandom_range(0, 99) < 6) begin
        // oversized length, possibly past 32 bits once origin and overhead add up
        len = $urandom_range(0, 1) ? (32'hFFFFFFF0 | 32'($urandom_range(0, 15)))
                                   : (32'h80000000 | $urandom);
        push_word(len);
        push_word(pick_kind());
        repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
        break;
      end
      push_word(len);
      push_word(pick_kind());
      repeat (len) push_byte(8'($urandom));
      push_word($urandom);
    end
    if ($urandom_range(0, 9) != 0 && file_q.size() >= 8) begin
      len = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(1, 5)) : 32'd0;
      push_word(len);
      push_word(IEND_TAG);
      repeat (len) push_byte(8'($urandom));
      push_word($urandom_range(0, 1) ? 32'hAE426082 : $urandom);
    end
    file_q[0][8] = 1'b1;
  endfunction

  initial begin
    int          r;
    int          iter;
    int          flen;
    bit          set_size;
    logic [31:0] fsz;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no start mark: first byte after reset opens a file; zero-length chunk
    // ends exactly at file_size, then the next length field does not fit
    write_size(32'd20);
    file_q.delete();
    push_word(32'h00FF00FF);
    push_word(32'h807F01FE);
    push_word(32'h00000000);
    push_word(32'h74455874);
    push_word(32'hFF00FF00);
    push_byte(8'hFF);
    push_byte(8'h00);
    send_file();

    iter = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        file_q.delete();
        repeat ($urandom_range(10, 30))
          file_q.insert(file_q.size(), {($urandom_range(0, 19) == 0), 8'($urandom)});
        if ($urandom_range(0, 4) != 0)
          file_q[0][8] = 1'b1;
        flen = file_q.size();
      end else begin
        build_file();
        flen = file_q.size();
        if ($urandom_range(0, 9) < 3)
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end

      set_size = 1'b1;
      r = $urandom_range(0, 99);
      if (iter == 0) fsz = SIZE_MAX;
      else if (iter == 1) fsz = '0;
      else if (iter == 2) fsz = flen;
      else if (r < 30) fsz = flen;
      else if (r < 40) fsz = flen - 1;
      else if (r < 50) fsz = flen + $urandom_range(1, 40);
      else if (r < 58) fsz = SIZE_MAX;
      else if (r < 62) fsz = '0;
      else if (r < 72) fsz = $urandom_range(0, flen);
      else set_size = 1'b0;
      if (set_size)
        write_size(fsz);

      no_gaps = ($urandom_range(0, 3) == 0);
      send_file();
      items_sent += flen;
      iter++;
    end
    s_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (records_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
